/* src/lift_lock_interlock_defines.svh */
// Assertion macros for the lift lock interlock.
`ifndef LIFT_LOCK_INTERLOCK_DEFINES_SVH
`define LIFT_LOCK_INTERLOCK_DEFINES_SVH

// Same-cycle implication, off during reset.
`define LLI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define LLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lli_pkg.sv */
// Shared constants and types for the lift lock interlock.
`timescale 1ns / 1ps

package lli_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WEIGHT_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_X_TOLERANCE      = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_Y_TOLERANCE      = 2'd2;

  localparam int THRESHOLD_RESET = 500;
  localparam int X_TOL_RESET     = 500;
  localparam int Y_TOL_RESET     = 1000;

  localparam logic REQ_POSITION = 1'b0;
  localparam logic REQ_WEIGHT   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_UNCHANGED  = 2'd0,
    STATUS_LIFT_START = 2'd1,
    STATUS_ALIGNING   = 2'd2,
    STATUS_LIFT_DONE  = 2'd3
  } lli_status_t;

  typedef struct packed {
    logic step;
    logic take;
  } lli_ctrl_t;

endpackage

/* src/lift_lock_interlock.sv */
// Lift lock interlock top level: input register, handshake and checks.
// A weight sample passes from the input register to the result register, loaded once the output is free.
// Throughput: one transaction per cycle while in_stall is low; the input and
// result registers are parted, so an item is taken while a finished result waits.
// A position update produces no result and only updates the crane position.
// Reset (rst, synchronous) clears all points to -1, arms ready and zeroes the count.
`timescale 1ns / 1ps
`include "lift_lock_interlock_defines.svh"

module lift_lock_interlock #(
  parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = lli_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [COORD_WIDTH-1:0]              arg_x,
  input  logic [COORD_WIDTH-1:0]              arg_y,
  input  logic [COORD_WIDTH-1:0]              arg_third,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                lock_valid,
  output logic                                lock_cmd,
  output logic                                report_request,
  output logic [1:0]                          status_code,
  output logic [COUNT_WIDTH-1:0]              batch_total,
  output logic [COORD_WIDTH-1:0]              log_x,
  output logic [COORD_WIDTH-1:0]              log_y,
  output logic [COORD_WIDTH-1:0]              log_weight,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lli_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data
);

  logic                   in_full;
  logic                   item_type;
  logic [COORD_WIDTH-1:0] item_x;
  logic [COORD_WIDTH-1:0] item_y;
  logic [COORD_WIDTH-1:0] item_third;
  logic                   out_free;
  lli_pkg::lli_ctrl_t     ctrl;

  assign out_free  = !out_valid || !out_stall;
  assign ctrl.step = in_full && ((item_type == lli_pkg::REQ_POSITION) || out_free);
  assign ctrl.take = out_valid && !out_stall;
  assign in_stall  = in_full && !ctrl.step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_type  <= req_type;
      item_x     <= arg_x;
      item_y     <= arg_y;
      item_third <= arg_third;
    end
  end

  lli_core #(
    .COORD_WIDTH(COORD_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .item_type     (item_type),
    .item_x        (item_x),
    .item_y        (item_y),
    .item_third    (item_third),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .lock_valid    (lock_valid),
    .lock_cmd      (lock_cmd),
    .report_request(report_request),
    .status_code   (status_code),
    .batch_total   (batch_total),
    .log_x         (log_x),
    .log_y         (log_y),
    .log_weight    (log_weight)
  );

  `LLI_ASSERT_IMPLY(a_lock_cmd_valid, clk, rst, out_valid && lock_cmd, lock_valid && report_request, "lock command without valid or report")
  `LLI_ASSERT_IMPLY(a_start_locks, clk, rst, out_valid && (status_code == lli_pkg::STATUS_LIFT_START), lock_valid && lock_cmd, "lift start without lock")
  `LLI_ASSERT_IMPLY(a_stall_needs_item, clk, rst, in_stall, in_full && out_valid, "stall without a held transaction")
  `LLI_ASSERT_NEXT(a_count_on_start, clk, rst, ctrl.step && (item_type == lli_pkg::REQ_WEIGHT) && (u_core.lift_count_next != u_core.lift_count), out_valid && (status_code == lli_pkg::STATUS_LIFT_START), "count moved without a lift start")

endmodule

/* src/lli_near.sv */
// Proximity compare of two xy points against the x and y tolerances.
`timescale 1ns / 1ps

module lli_near #(
  parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEF
) (
  input  logic [COORD_WIDTH-1:0] ax,
  input  logic [COORD_WIDTH-1:0] ay,
  input  logic [COORD_WIDTH-1:0] bx,
  input  logic [COORD_WIDTH-1:0] by,
  input  logic [COORD_WIDTH-1:0] x_tol,
  input  logic [COORD_WIDTH-1:0] y_tol,
  output logic                   near
);

  logic [COORD_WIDTH:0] dx;
  logic [COORD_WIDTH:0] dy;
  logic [COORD_WIDTH:0] adx;
  logic [COORD_WIDTH:0] ady;

  assign dx  = {ax[COORD_WIDTH-1], ax} - {bx[COORD_WIDTH-1], bx};
  assign dy  = {ay[COORD_WIDTH-1], ay} - {by[COORD_WIDTH-1], by};
  assign adx = dx[COORD_WIDTH] ? (~dx + 1'b1) : dx;
  assign ady = dy[COORD_WIDTH] ? (~dy + 1'b1) : dy;

  assign near = (adx < {1'b0, x_tol}) && (ady < {1'b0, y_tol});

endmodule

/* src/lli_core.sv */
// Interlock state, configuration registers, step logic and result register.
`timescale 1ns / 1ps

module lli_core #(
  parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = lli_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lli_pkg::lli_ctrl_t                  ctrl,
  input  logic                                item_type,
  input  logic [COORD_WIDTH-1:0]              item_x,
  input  logic [COORD_WIDTH-1:0]              item_y,
  input  logic [COORD_WIDTH-1:0]              item_third,
  input  logic                                cfg_we,
  input  logic [lli_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data,
  output logic                                out_valid,
  output logic                                lock_valid,
  output logic                                lock_cmd,
  output logic                                report_request,
  output logic [1:0]                          status_code,
  output logic [COUNT_WIDTH-1:0]              batch_total,
  output logic [COORD_WIDTH-1:0]              log_x,
  output logic [COORD_WIDTH-1:0]              log_y,
  output logic [COORD_WIDTH-1:0]              log_weight
);

  localparam logic [COORD_WIDTH-1:0] UNKNOWN = '1;

  logic [COORD_WIDTH-1:0] weight_threshold;
  logic [COORD_WIDTH-1:0] x_tolerance;
  logic [COORD_WIDTH-1:0] y_tolerance;

  logic [COORD_WIDTH-1:0] crane_x, crane_y, crane_z;
  logic [COORD_WIDTH-1:0] release_x, release_y, release_z;
  logic [COORD_WIDTH-1:0] pickup_x, pickup_y, pickup_z;
  logic                   lifting;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] lift_count;

  logic [COORD_WIDTH-1:0] release_x_next, release_y_next, release_z_next;
  logic [COORD_WIDTH-1:0] pickup_x_next, pickup_y_next, pickup_z_next;
  logic                   lifting_next;
  logic                   ready_next;
  logic [COUNT_WIDTH-1:0] lift_count_next;
  logic                   lv, lc, rr;
  lli_pkg::lli_status_t   st;

  logic near_rc, near_rp, near_cp;
  logic release_known, pickup_known;
  logic weight_step;

  lli_near #(.COORD_WIDTH(COORD_WIDTH)) u_near_rc (
    .ax(release_x), .ay(release_y), .bx(crane_x), .by(crane_y),
    .x_tol(x_tolerance), .y_tol(y_tolerance), .near(near_rc)
  );

  lli_near #(.COORD_WIDTH(COORD_WIDTH)) u_near_rp (
    .ax(release_x), .ay(release_y), .bx(pickup_x), .by(pickup_y),
    .x_tol(x_tolerance), .y_tol(y_tolerance), .near(near_rp)
  );

  lli_near #(.COORD_WIDTH(COORD_WIDTH)) u_near_cp (
    .ax(crane_x), .ay(crane_y), .bx(pickup_x), .by(pickup_y),
    .x_tol(x_tolerance), .y_tol(y_tolerance), .near(near_cp)
  );

  assign release_known = (release_x != UNKNOWN) && (release_y != UNKNOWN) &&
                         (release_z != UNKNOWN);
  assign pickup_known  = (pickup_x != UNKNOWN) && (pickup_y != UNKNOWN) &&
                         (pickup_z != UNKNOWN);
  assign weight_step   = ctrl.step && (item_type == lli_pkg::REQ_WEIGHT);

  always_comb begin
    logic ready_arm;
    logic clear_pts;
    logic pickup_after;
    logic above;
    logic below;

    ready_arm    = release_known ? (!near_rc || (pickup_known && near_rp)) : ready;
    clear_pts    = release_known && ready_arm;
    pickup_after = clear_pts ? 1'b0 : pickup_known;
    above        = $signed(item_third) > $signed(weight_threshold);
    below        = $signed(item_third) < $signed(weight_threshold);

    release_x_next  = clear_pts ? UNKNOWN : release_x;
    release_y_next  = clear_pts ? UNKNOWN : release_y;
    release_z_next  = clear_pts ? UNKNOWN : release_z;
    pickup_x_next   = clear_pts ? UNKNOWN : pickup_x;
    pickup_y_next   = clear_pts ? UNKNOWN : pickup_y;
    pickup_z_next   = clear_pts ? UNKNOWN : pickup_z;
    lifting_next    = lifting;
    ready_next      = ready_arm;
    lift_count_next = lift_count;
    lv = 1'b0;
    lc = 1'b0;
    rr = 1'b0;
    st = lli_pkg::STATUS_UNCHANGED;

    if (above) begin
      if (!lifting && ready_arm) begin
        pickup_x_next   = crane_x;
        pickup_y_next   = crane_y;
        pickup_z_next   = crane_z;
        lift_count_next = lift_count + 1'b1;
        lifting_next    = 1'b1;
        ready_next      = 1'b0;
        lv = 1'b1;
        lc = 1'b1;
        rr = 1'b1;
        st = lli_pkg::STATUS_LIFT_START;
      end else if (!lifting) begin
        st = lli_pkg::STATUS_ALIGNING;
      end
    end else if (below) begin
      if (!lifting) begin
        st = lli_pkg::STATUS_LIFT_DONE;
      end else begin
        release_x_next = crane_x;
        release_y_next = crane_y;
        release_z_next = crane_z;
        if (!(pickup_after && near_cp)) begin
          lifting_next = 1'b0;
          lv = 1'b1;
          rr = 1'b1;
          st = lli_pkg::STATUS_LIFT_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_threshold <= COORD_WIDTH'(lli_pkg::THRESHOLD_RESET);
      x_tolerance      <= COORD_WIDTH'(lli_pkg::X_TOL_RESET);
      y_tolerance      <= COORD_WIDTH'(lli_pkg::Y_TOL_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        lli_pkg::CFG_WEIGHT_THRESHOLD: weight_threshold <= cfg_data;
        lli_pkg::CFG_X_TOLERANCE:      x_tolerance      <= cfg_data;
        lli_pkg::CFG_Y_TOLERANCE:      y_tolerance      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crane_x    <= UNKNOWN;
      crane_y    <= UNKNOWN;
      crane_z    <= UNKNOWN;
      release_x  <= UNKNOWN;
      release_y  <= UNKNOWN;
      release_z  <= UNKNOWN;
      pickup_x   <= UNKNOWN;
      pickup_y   <= UNKNOWN;
      pickup_z   <= UNKNOWN;
      lifting    <= 1'b0;
      ready      <= 1'b1;
      lift_count <= '0;
    end else if (ctrl.step) begin
      if (item_type == lli_pkg::REQ_POSITION) begin
        crane_x <= item_x;
        crane_y <= item_y;
        crane_z <= item_third;
      end else begin
        release_x  <= release_x_next;
        release_y  <= release_y_next;
        release_z  <= release_z_next;
        pickup_x   <= pickup_x_next;
        pickup_y   <= pickup_y_next;
        pickup_z   <= pickup_z_next;
        lifting    <= lifting_next;
        ready      <= ready_next;
        lift_count <= lift_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (weight_step) begin
      out_valid <= 1'b1;
    end else if (ctrl.take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (weight_step) begin
      lock_valid     <= lv;
      lock_cmd       <= lc;
      report_request <= rr;
      status_code    <= st;
      batch_total    <= lift_count_next;
      log_x          <= item_x;
      log_y          <= item_y;
      log_weight     <= item_third;
    end
  end

endmodule
